// ----- rtl/afod_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afod_pkg: shared types and constants of the face orientation detector
// Holds the sample width, face and register codes, the configuration
// bundle and the axis-to-face lookup.
// ----------------------------------------------------------------------------
package afod_pkg;

	// sample width of each acceleration axis
	localparam int SAMPLE_BITS = 19;
	localparam int THR_W       = 18;
	localparam int SHIFT_W     = 3;
	localparam int STABLE_W    = 4;
	localparam int MAG_W       = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;
	localparam int NUM_AXES    = 3;

	// configuration port geometry
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	// face queue between classifier and confirmer
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// register reset values
	localparam logic [SHIFT_W-1:0]  AVERAGE_SHIFT_RST     = SHIFT_W'(2);
	localparam logic [THR_W-1:0]    GRAVITY_THRESHOLD_RST = THR_W'(6000);
	localparam logic [STABLE_W-1:0] STABLE_SAMPLES_RST    = STABLE_W'(5);

	typedef enum logic [2:0] {
		FACE_UNKNOWN = 3'd0,
		FACE_TOP     = 3'd1,
		FACE_BOTTOM  = 3'd2,
		FACE_FRONT   = 3'd3,
		FACE_BACK    = 3'd4,
		FACE_RIGHT   = 3'd5,
		FACE_LEFT    = 3'd6
	} face_t;

	typedef enum logic [1:0] {
		AXIS_X = 2'd0,
		AXIS_Y = 2'd1,
		AXIS_Z = 2'd2
	} axis_t;

	typedef enum logic [1:0] {
		REG_AVERAGE_SHIFT     = 2'd0,
		REG_GRAVITY_THRESHOLD = 2'd1,
		REG_STABLE_SAMPLES    = 2'd2
	} reg_idx_t;

	// configuration bundle handed to the front and back parts
	typedef struct packed {
		logic [SHIFT_W-1:0]  average_shift;
		logic [THR_W-1:0]    gravity_threshold;
		logic [STABLE_W-1:0] stable_samples;
	} cfg_t;

	// face picked by the dominant axis and its sign
	function automatic face_t face_of(input axis_t axis, input logic positive);
		face_t f;
		unique case (axis)
			AXIS_X:  f = positive ? FACE_BACK   : FACE_FRONT;
			AXIS_Y:  f = positive ? FACE_LEFT   : FACE_RIGHT;
			AXIS_Z:  f = positive ? FACE_BOTTOM : FACE_TOP;
			default: f = FACE_UNKNOWN;
		endcase
		return f;
	endfunction

endpackage

// ----- rtl/afod_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afod_front: sample intake, running average and face classification
// Accepts one sample word a cycle while the queue has room, updates the
// per-axis averages and pushes the instant face of the averages to the queue.
// ----------------------------------------------------------------------------
module afod_front (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  afod_pkg::cfg_t                       cfg,
	input  logic                                 sample_valid,
	output logic                                 sample_stall,
	input  logic signed [afod_pkg::SAMPLE_BITS-1:0] accel_x,
	input  logic signed [afod_pkg::SAMPLE_BITS-1:0] accel_y,
	input  logic signed [afod_pkg::SAMPLE_BITS-1:0] accel_z,
	input  logic                                 queue_full,
	output logic                                 push,
	output afod_pkg::face_t                      push_face
);

	localparam int SB = afod_pkg::SAMPLE_BITS;

	logic signed [SB-1:0] raw_w    [afod_pkg::NUM_AXES];
	logic signed [SB-1:0] avg_nx_w [afod_pkg::NUM_AXES];
	logic signed [SB:0]   diff_w   [afod_pkg::NUM_AXES];
	logic signed [SB:0]   step_w   [afod_pkg::NUM_AXES];
	logic signed [SB:0]   sum_w    [afod_pkg::NUM_AXES];
	logic [SB-1:0]        mag_w    [afod_pkg::NUM_AXES];

	logic signed [SB-1:0] avg_q [afod_pkg::NUM_AXES];
	logic                 loaded_q;
	logic                 valid_s1;

	logic                 accept;
	logic [SB-1:0]        best_w;
	afod_pkg::axis_t      dom_w;
	logic                 positive_w;

	assign raw_w[0] = accel_x;
	assign raw_w[1] = accel_y;
	assign raw_w[2] = accel_z;

	// handshake: the held word leaves whenever the queue has room
	assign sample_stall = valid_s1 && queue_full;
	assign accept       = sample_valid && !sample_stall;
	assign push         = valid_s1 && !queue_full;

	// running average step per axis
	always_comb begin
		for (int i = 0; i < afod_pkg::NUM_AXES; i++) begin
			diff_w[i] = {raw_w[i][SB-1], raw_w[i]} - {avg_q[i][SB-1], avg_q[i]};
			step_w[i] = diff_w[i] >>> cfg.average_shift;
			sum_w[i]  = {avg_q[i][SB-1], avg_q[i]} + step_w[i];
			avg_nx_w[i] = loaded_q ? sum_w[i][SB-1:0] : raw_w[i];
		end
	end

	// average state and held-word flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < afod_pkg::NUM_AXES; i++) begin
				avg_q[i] <= '0;
			end
			loaded_q <= 1'b0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				for (int i = 0; i < afod_pkg::NUM_AXES; i++) begin
					avg_q[i] <= avg_nx_w[i];
				end
				loaded_q <= 1'b1;
				valid_s1 <= 1'b1;
			end else if (push) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	// magnitudes of the held averages
	always_comb begin
		for (int i = 0; i < afod_pkg::NUM_AXES; i++) begin
			mag_w[i] = avg_q[i][SB-1] ? (~avg_q[i] + SB'(1)) : avg_q[i];
		end
	end

	// dominant axis, earlier axis wins a tie
	always_comb begin
		best_w = mag_w[0];
		dom_w  = afod_pkg::AXIS_X;
		if (mag_w[1] > best_w) begin
			best_w = mag_w[1];
			dom_w  = afod_pkg::AXIS_Y;
		end
		if (mag_w[2] > best_w) begin
			best_w = mag_w[2];
			dom_w  = afod_pkg::AXIS_Z;
		end
		positive_w = !avg_q[dom_w][SB-1] && (|avg_q[dom_w]);
	end

	// threshold check and face lookup
	always_comb begin
		if (afod_pkg::MAG_W'(best_w) < afod_pkg::MAG_W'(cfg.gravity_threshold)) begin
			push_face = afod_pkg::FACE_UNKNOWN;
		end else begin
			push_face = afod_pkg::face_of(dom_w, positive_w);
		end
	end

endmodule

// ----- rtl/afod_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afod_queue: short face queue
// Decouples the classifier from the confirmer so that either side can
// stall on its own.
// ----------------------------------------------------------------------------
module afod_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  afod_pkg::face_t push_face,
	output logic            full,
	input  logic            pop,
	output afod_pkg::face_t pop_face,
	output logic            empty
);

	afod_pkg::face_t                 entry_q [afod_pkg::QUEUE_DEPTH];
	logic [afod_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [afod_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [afod_pkg::QCNT_W-1:0]     count_q;

	assign full     = (count_q == afod_pkg::QCNT_W'(afod_pkg::QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign pop_face = entry_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_face;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + afod_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + afod_pkg::QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + afod_pkg::QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - afod_pkg::QCNT_W'(1);
			end
		end
	end

endmodule

// ----- rtl/afod_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afod_back: face confirmation and result register
// Tracks the candidate face and its run, confirms a face change and
// holds the result word until the consumer takes it.
// ----------------------------------------------------------------------------
module afod_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  afod_pkg::cfg_t                cfg,
	input  logic                          empty,
	input  afod_pkg::face_t               pop_face,
	output logic                          pop,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic                          face_changed,
	output logic [2:0]                    confirmed_face,
	output logic [2:0]                    prior_face,
	output logic [2:0]                    instant_face
);

	localparam int SW = afod_pkg::STABLE_W;

	afod_pkg::face_t cand_q;
	afod_pkg::face_t cur_q;
	logic [SW-1:0]   run_q;

	afod_pkg::face_t cand_nx;
	afod_pkg::face_t cur_nx;
	logic [SW-1:0]   run_nx;
	logic [SW-1:0]   need_w;
	logic            changed_w;

	logic            out_valid_q;
	logic            changed_q;
	afod_pkg::face_t confirmed_q;
	afod_pkg::face_t previous_q;
	afod_pkg::face_t instant_q;

	assign pop = !empty && (!out_valid_q || !result_stall);

	// candidate tracking and confirmation
	always_comb begin
		need_w = (cfg.stable_samples == '0) ? SW'(1) : cfg.stable_samples;
		cand_nx = cand_q;
		run_nx  = run_q;
		if (pop_face == afod_pkg::FACE_UNKNOWN || pop_face != cand_q) begin
			cand_nx = pop_face;
			run_nx  = '0;
		end else if (run_q < need_w) begin
			run_nx = run_q + SW'(1);
		end
		cur_nx    = cur_q;
		changed_w = 1'b0;
		if (run_nx >= need_w && cand_nx != cur_q) begin
			cur_nx    = cand_nx;
			changed_w = 1'b1;
		end
	end

	// tracking state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_q <= afod_pkg::FACE_UNKNOWN;
			cur_q  <= afod_pkg::FACE_UNKNOWN;
			run_q  <= '0;
		end else if (pop) begin
			cand_q <= cand_nx;
			cur_q  <= cur_nx;
			run_q  <= run_nx;
		end
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (pop) begin
			changed_q   <= changed_w;
			confirmed_q <= cur_nx;
			previous_q  <= cur_q;
			instant_q   <= pop_face;
		end
	end

	assign result_valid   = out_valid_q;
	assign face_changed   = changed_q;
	assign confirmed_face = confirmed_q;
	assign prior_face     = previous_q;
	assign instant_face   = instant_q;

endmodule

// ----- rtl/accel_face_orientation_detector.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accel_face_orientation_detector: accelerometer face orientation detector
// Throughput: one sample word per cycle while the face queue has room;
// the averages are registered, classified into a four-entry face queue and
// confirmed into the registered result word.
// Reset: averages, candidate and current face clear to zero (unknown), the
// registers take their defaults, and no word is held anywhere.
// ----------------------------------------------------------------------------
module accel_face_orientation_detector (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 sample_valid,
	output logic                                 sample_stall,
	input  logic signed [afod_pkg::SAMPLE_BITS-1:0] accel_x,
	input  logic signed [afod_pkg::SAMPLE_BITS-1:0] accel_y,
	input  logic signed [afod_pkg::SAMPLE_BITS-1:0] accel_z,
	output logic                                 result_valid,
	input  logic                                 result_stall,
	output logic                                 face_changed,
	output logic [2:0]                           confirmed_face,
	output logic [2:0]                           prior_face,
	output logic [2:0]                           instant_face,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [afod_pkg::ADDR_W-1:0]          paddr,
	input  logic [afod_pkg::DATA_W-1:0]          pwdata,
	output logic [afod_pkg::DATA_W-1:0]          prdata,
	output logic                                 pready
);

	afod_pkg::cfg_t     cfg_q;
	afod_pkg::reg_idx_t reg_idx;
	logic               cfg_write;

	logic               queue_full;
	logic               queue_empty;
	logic               push;
	logic               pop;
	afod_pkg::face_t    push_face;
	afod_pkg::face_t    pop_face;

	assign pready    = 1'b1;
	assign reg_idx   = afod_pkg::reg_idx_t'(paddr[3:2]);
	assign cfg_write = psel && penable && pwrite && pready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.average_shift     <= afod_pkg::AVERAGE_SHIFT_RST;
			cfg_q.gravity_threshold <= afod_pkg::GRAVITY_THRESHOLD_RST;
			cfg_q.stable_samples    <= afod_pkg::STABLE_SAMPLES_RST;
		end else if (cfg_write) begin
			unique case (reg_idx)
				afod_pkg::REG_AVERAGE_SHIFT: begin
					cfg_q.average_shift <= pwdata[afod_pkg::SHIFT_W-1:0];
				end
				afod_pkg::REG_GRAVITY_THRESHOLD: begin
					cfg_q.gravity_threshold <= pwdata[afod_pkg::THR_W-1:0];
				end
				afod_pkg::REG_STABLE_SAMPLES: begin
					cfg_q.stable_samples <= pwdata[afod_pkg::STABLE_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// register read back
	always_comb begin
		unique case (reg_idx)
			afod_pkg::REG_AVERAGE_SHIFT: begin
				prdata = afod_pkg::DATA_W'(cfg_q.average_shift);
			end
			afod_pkg::REG_GRAVITY_THRESHOLD: begin
				prdata = afod_pkg::DATA_W'(cfg_q.gravity_threshold);
			end
			afod_pkg::REG_STABLE_SAMPLES: begin
				prdata = afod_pkg::DATA_W'(cfg_q.stable_samples);
			end
			default: begin
				prdata = '0;
			end
		endcase
	end

	// intake, averaging and classification
	afod_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.accel_x      (accel_x),
		.accel_y      (accel_y),
		.accel_z      (accel_z),
		.queue_full   (queue_full),
		.push         (push),
		.push_face    (push_face)
	);

	// face queue
	afod_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_face (push_face),
		.full      (queue_full),
		.pop       (pop),
		.pop_face  (pop_face),
		.empty     (queue_empty)
	);

	// confirmation and result register
	afod_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.empty          (queue_empty),
		.pop_face       (pop_face),
		.pop            (pop),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.face_changed   (face_changed),
		.confirmed_face (confirmed_face),
		.prior_face     (prior_face),
		.instant_face   (instant_face)
	);

endmodule

// ----- verif/accel_face_orientation_detector_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accel_face_orientation_detector_tb: self-checking bench of the face detector
// A queue-fed driver pushes acceleration sample words with random gaps while
// the result side stalls at random. Every accepted sample is run through a
// local predictor of the running average, the dominant axis pick and the face
// confirmation. Each result word is checked field by field in order. The run
// walks through several register settings, extremes among them, written over
// the configuration port only while the block is idle.
// ----------------------------------------------------------------------------
module accel_face_orientation_detector_tb;

	localparam int SAMPLE_MAX    = (1 << (afod_pkg::SAMPLE_BITS - 1)) - 1;
	localparam int SAMPLE_MIN    = -(1 << (afod_pkg::SAMPLE_BITS - 1));
	localparam int RANDOM_PHASES = 10;
	localparam int PHASE_SAMPLES = 120;
	localparam logic [1:0] REG_SPARE = 2'd3;

	typedef logic signed [afod_pkg::SAMPLE_BITS-1:0] sample_t;

	typedef struct packed {
		sample_t x;
		sample_t y;
		sample_t z;
	} accel_word_t;

	typedef struct packed {
		logic            changed;
		afod_pkg::face_t confirmed;
		afod_pkg::face_t previous;
		afod_pkg::face_t instant;
	} face_word_t;

	// block ports
	logic                        clk          = 1'b0;
	logic                        arst_n       = 1'b0;
	logic                        sample_valid = 1'b0;
	logic                        sample_stall;
	sample_t                     accel_x      = '0;
	sample_t                     accel_y      = '0;
	sample_t                     accel_z      = '0;
	logic                        result_valid;
	logic                        result_stall = 1'b0;
	logic                        face_changed;
	logic [2:0]                  confirmed_face;
	logic [2:0]                  prior_face;
	logic [2:0]                  instant_face;
	logic                        psel         = 1'b0;
	logic                        penable      = 1'b0;
	logic                        pwrite       = 1'b0;
	logic [afod_pkg::ADDR_W-1:0] paddr        = '0;
	logic [afod_pkg::DATA_W-1:0] pwdata       = '0;
	logic [afod_pkg::DATA_W-1:0] prdata;
	logic                        pready;

	// bench state
	accel_word_t sample_backlog [$];
	face_word_t  expected_faces [$];
	logic        sample_taken   = 1'b0;
	int          tx_gap         = 0;
	int          rx_stall_left  = 0;
	bit          idle_tx        = 1'b1;
	bit          idle_rx        = 1'b1;
	int          mismatch_count = 0;

	// predictor copy of the registers and the detector state
	logic [afod_pkg::SHIFT_W-1:0]  shift_cfg  = afod_pkg::AVERAGE_SHIFT_RST;
	logic [afod_pkg::THR_W-1:0]    thr_cfg    = afod_pkg::GRAVITY_THRESHOLD_RST;
	logic [afod_pkg::STABLE_W-1:0] stable_cfg = afod_pkg::STABLE_SAMPLES_RST;
	sample_t                       avg_axis [afod_pkg::NUM_AXES] = '{default: '0};
	logic                          avg_loaded = 1'b0;
	afod_pkg::face_t               cand_face  = afod_pkg::FACE_UNKNOWN;
	logic [afod_pkg::STABLE_W-1:0] cand_run   = '0;
	afod_pkg::face_t               held_face  = afod_pkg::FACE_UNKNOWN;

	accel_face_orientation_detector i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.sample_valid   (sample_valid),
		.sample_stall   (sample_stall),
		.accel_x        (accel_x),
		.accel_y        (accel_y),
		.accel_z        (accel_z),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.face_changed   (face_changed),
		.confirmed_face (confirmed_face),
		.prior_face     (prior_face),
		.instant_face   (instant_face),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// average, classify and confirm one sample word
	task automatic predict_orientation(input accel_word_t s, output face_word_t r);
		sample_t                               raw [afod_pkg::NUM_AXES];
		logic signed [afod_pkg::SAMPLE_BITS:0] diff;
		logic signed [afod_pkg::SAMPLE_BITS:0] wide;
		logic [afod_pkg::SAMPLE_BITS:0]        mag;
		logic [afod_pkg::SAMPLE_BITS:0]        best;
		logic [afod_pkg::STABLE_W-1:0]         need;
		afod_pkg::face_t                       face;
		int                                    dom;
		int                                    i;
		raw[0] = s.x;
		raw[1] = s.y;
		raw[2] = s.z;
		for (i = 0; i < afod_pkg::NUM_AXES; i++) begin
			if (!avg_loaded) begin
				avg_axis[i] = raw[i];
			end else begin
				diff = {raw[i][afod_pkg::SAMPLE_BITS-1], raw[i]}
					- {avg_axis[i][afod_pkg::SAMPLE_BITS-1], avg_axis[i]};
				diff = diff >>> shift_cfg;
				avg_axis[i] = avg_axis[i] + diff[afod_pkg::SAMPLE_BITS-1:0];
			end
		end
		avg_loaded = 1'b1;

		// dominant axis, earlier axis wins a tie
		dom  = 0;
		best = '0;
		for (i = 0; i < afod_pkg::NUM_AXES; i++) begin
			wide = {avg_axis[i][afod_pkg::SAMPLE_BITS-1], avg_axis[i]};
			mag  = (wide < 0) ? -wide : wide;
			if (i == 0 || mag > best) begin
				best = mag;
				dom  = i;
			end
		end
		if (best < thr_cfg) begin
			face = afod_pkg::FACE_UNKNOWN;
		end else begin
			case (dom)
				afod_pkg::AXIS_X: begin
					face = (avg_axis[dom] > 0) ? afod_pkg::FACE_BACK : afod_pkg::FACE_FRONT;
				end
				afod_pkg::AXIS_Y: begin
					face = (avg_axis[dom] > 0) ? afod_pkg::FACE_LEFT : afod_pkg::FACE_RIGHT;
				end
				default: begin
					face = (avg_axis[dom] > 0) ? afod_pkg::FACE_BOTTOM : afod_pkg::FACE_TOP;
				end
			endcase
		end

		// candidate run and confirmation
		need       = (stable_cfg == '0) ? afod_pkg::STABLE_W'(1) : stable_cfg;
		r.previous = held_face;
		r.changed  = 1'b0;
		if (face == afod_pkg::FACE_UNKNOWN || face != cand_face) begin
			cand_face = face;
			cand_run  = '0;
		end else if (cand_run < need) begin
			cand_run = cand_run + 1'b1;
		end
		if (cand_run >= need && cand_face != held_face) begin
			held_face = cand_face;
			r.changed = 1'b1;
		end
		r.confirmed = held_face;
		r.instant   = face;
	endtask

	task automatic report_mismatch(input string what, input logic [7:0] want,
			input logic [7:0] got);
		mismatch_count++;
		$display("mismatch at %0t: %s expected %0h got %0h", $time, what, want, got);
	endtask

	// gap length: mostly short, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(3, 1);
		if (r < 97) return $urandom_range(12, 4);
		return $urandom_range(60, 20);
	endfunction

	function automatic int saturate(input int v);
		if (v > SAMPLE_MAX) return SAMPLE_MAX;
		if (v < SAMPLE_MIN) return SAMPLE_MIN;
		return v;
	endfunction

	// dominant magnitude: mostly above the threshold, some below, some on it
	function automatic int pick_magnitude();
		int r;
		r = $urandom_range(9);
		if (r < 7) return $urandom_range(SAMPLE_MAX, int'(thr_cfg));
		if (r < 9) return $urandom_range(int'(thr_cfg), 0);
		if (thr_cfg == '0) return 0;
		return int'(thr_cfg) - int'($urandom_range(1));
	endfunction

	function automatic int edge_value();
		case ($urandom_range(7))
			0:       return SAMPLE_MAX;
			1:       return SAMPLE_MIN;
			2:       return 0;
			3:       return 1;
			4:       return -1;
			5:       return int'(thr_cfg);
			6:       return -int'(thr_cfg);
			default: return int'(thr_cfg) - 1;
		endcase
	endfunction

	task automatic queue_sample(input int x, input int y, input int z);
		accel_word_t w;
		w.x = sample_t'(x);
		w.y = sample_t'(y);
		w.z = sample_t'(z);
		sample_backlog.push_back(w);
	endtask

	// mostly steady orientations with noise, the rest raw noise, edge values and equal-magnitude axis pairs
	task automatic queue_random_samples(input int count);
		int left;
		int run;
		int axis;
		int other;
		int mag;
		int kind;
		int k;
		int i;
		int base [afod_pkg::NUM_AXES];
		int v [afod_pkg::NUM_AXES];
		bit positive;
		left = count;
		while (left > 0) begin
			kind = $urandom_range(99);
			if (kind < 70) begin
				run      = $urandom_range(40, 1);
				axis     = $urandom_range(afod_pkg::NUM_AXES - 1);
				positive = ($urandom_range(1) != 0);
				mag      = pick_magnitude();
				for (i = 0; i < afod_pkg::NUM_AXES; i++) begin
					base[i] = int'($urandom_range(mag)) - mag / 2;
				end
				base[axis] = positive ? mag : -mag;
				for (k = 0; k < run && left > 0; k++) begin
					for (i = 0; i < afod_pkg::NUM_AXES; i++) begin
						v[i] = base[i] + int'($urandom_range(64)) - 32;
					end
					queue_sample(saturate(v[0]), saturate(v[1]), saturate(v[2]));
					left--;
				end
			end else if (kind < 85) begin
				queue_sample(int'(sample_t'($urandom)), int'(sample_t'($urandom)),
					int'(sample_t'($urandom)));
				left--;
			end else if (kind < 95) begin
				queue_sample(edge_value(), edge_value(), edge_value());
				left--;
			end else begin
				// two axes of equal magnitude
				mag   = pick_magnitude();
				axis  = $urandom_range(afod_pkg::NUM_AXES - 1);
				other = (axis + 1 + $urandom_range(1)) % afod_pkg::NUM_AXES;
				for (i = 0; i < afod_pkg::NUM_AXES; i++) begin
					v[i] = int'($urandom_range(mag)) / 2;
				end
				v[axis]  = $urandom_range(1) ? mag : -mag;
				v[other] = $urandom_range(1) ? mag : -mag;
				queue_sample(saturate(v[0]), saturate(v[1]), saturate(v[2]));
				left--;
			end
		end
	endtask

	task automatic wait_drained();
		do @(posedge clk);
		while (sample_backlog.size() != 0 || sample_valid || expected_faces.size() != 0);
	endtask

	// register write: setup cycle, then access cycle until pready
	task automatic write_reg(input logic [1:0] idx,
			input logic [afod_pkg::DATA_W-1:0] value);
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = afod_pkg::ADDR_W'({idx, 2'b00});
		pwdata  = value;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk);
		while (!pready);
		case (idx)
			afod_pkg::REG_AVERAGE_SHIFT:     shift_cfg  = value[afod_pkg::SHIFT_W-1:0];
			afod_pkg::REG_GRAVITY_THRESHOLD: thr_cfg    = value[afod_pkg::THR_W-1:0];
			afod_pkg::REG_STABLE_SAMPLES:    stable_cfg = value[afod_pkg::STABLE_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	// sample word taken: record it and predict its result
	always @(posedge clk) begin : sample_capture
		accel_word_t s;
		face_word_t  r;
		sample_taken <= sample_valid && !sample_stall;
		if (sample_valid && !sample_stall) begin
			s.x = accel_x;
			s.y = accel_y;
			s.z = accel_z;
			predict_orientation(s, r);
			expected_faces.push_back(r);
		end
	end

	// sample driver: next word once the current one is taken
	always @(negedge clk) begin : sample_driver
		accel_word_t w;
		if (arst_n && (!sample_valid || sample_taken)) begin
			if (tx_gap > 0) begin
				tx_gap--;
				sample_valid <= 1'b0;
			end else if (sample_backlog.size() != 0) begin
				w = sample_backlog.pop_front();
				accel_x      <= w.x;
				accel_y      <= w.y;
				accel_z      <= w.z;
				sample_valid <= 1'b1;
				tx_gap = idle_tx ? pick_gap() : 0;
			end else begin
				sample_valid <= 1'b0;
			end
		end
	end

	// result side back-pressure
	always @(negedge clk) begin : result_receiver
		if (arst_n) begin
			if (rx_stall_left > 0) begin
				rx_stall_left--;
				result_stall <= 1'b1;
			end else begin
				rx_stall_left = idle_rx ? pick_gap() : 0;
				result_stall <= (rx_stall_left > 0);
				if (rx_stall_left > 0) rx_stall_left--;
			end
		end
	end

	// result monitor: compare against the oldest prediction
	always @(posedge clk) begin : result_monitor
		face_word_t want;
		if (result_valid && !result_stall) begin
			if (expected_faces.size() == 0) begin
				report_mismatch("result word with nothing pending", 8'h0, 8'h0);
			end else begin
				want = expected_faces.pop_front();
				if (face_changed !== want.changed)
					report_mismatch("face_changed", 8'(want.changed), 8'(face_changed));
				if (confirmed_face !== want.confirmed)
					report_mismatch("confirmed_face", 8'(want.confirmed),
						8'(confirmed_face));
				if (prior_face !== want.previous)
					report_mismatch("prior_face", 8'(want.previous), 8'(prior_face));
				if (instant_face !== want.instant)
					report_mismatch("instant_face", 8'(want.instant), 8'(instant_face));
			end
		end
	end

	// phases of stimulus with register changes in between
	initial begin : stimulus
		int                            p;
		logic [afod_pkg::DATA_W-1:0]   junk;
		logic [afod_pkg::SHIFT_W-1:0]  sh;
		logic [afod_pkg::THR_W-1:0]    th;
		logic [afod_pkg::STABLE_W-1:0] st;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings: first word loaded as is, then confirmed after the run
		repeat (7) queue_sample(20000, -300, 150);
		queue_sample(100, 50, -20);
		wait_drained();

		// no smoothing, zero threshold, zero run length acting as one
		write_reg(afod_pkg::REG_AVERAGE_SHIFT, '0);
		write_reg(afod_pkg::REG_GRAVITY_THRESHOLD, '0);
		write_reg(afod_pkg::REG_STABLE_SAMPLES, '0);
		repeat (2) queue_sample(0, 0, 0);
		repeat (2) queue_sample(SAMPLE_MAX, 0, 0);
		repeat (2) queue_sample(SAMPLE_MIN, 0, 0);
		repeat (2) queue_sample(0, SAMPLE_MAX, 0);
		repeat (2) queue_sample(0, SAMPLE_MIN, 0);
		repeat (2) queue_sample(0, 0, SAMPLE_MAX);
		repeat (2) queue_sample(0, 0, SAMPLE_MIN);
		queue_sample(5, -5, 0);
		queue_sample(0, 7, -7);
		queue_sample(SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MAX);
		queue_sample(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX);
		queue_sample(SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN);
		wait_drained();

		for (p = 0; p < RANDOM_PHASES; p++) begin
			junk = '0;
			case (p)
				0: begin sh = afod_pkg::AVERAGE_SHIFT_RST; th = afod_pkg::GRAVITY_THRESHOLD_RST;
					st = afod_pkg::STABLE_SAMPLES_RST; end
				1: begin sh = '1; th = '1; st = '1; end
				2: begin sh = '0; th = '0; st = afod_pkg::STABLE_W'(1); end
				3: begin sh = '1; th = '0; st = '1; end
				4: begin sh = '0; th = '1; st = '0; end
				default: begin
					junk = $urandom;
					sh   = afod_pkg::SHIFT_W'($urandom_range(7));
					th   = $urandom_range(1) ? afod_pkg::THR_W'($urandom_range(20000, 1000))
						: afod_pkg::THR_W'($urandom_range((1 << afod_pkg::THR_W) - 1));
					st   = afod_pkg::STABLE_W'($urandom_range(15));
				end
			endcase
			idle_tx = (p == 2 || p == 4) ? 1'b0 : 1'b1;
			idle_rx = (p == 2 || p == 3) ? 1'b0 : 1'b1;

			// upper bits of the written data are don't-care
			write_reg(afod_pkg::REG_AVERAGE_SHIFT,
				{junk[afod_pkg::DATA_W-1:afod_pkg::SHIFT_W], sh});
			write_reg(afod_pkg::REG_GRAVITY_THRESHOLD,
				{junk[afod_pkg::DATA_W-1:afod_pkg::THR_W], th});
			write_reg(afod_pkg::REG_STABLE_SAMPLES,
				{junk[afod_pkg::DATA_W-1:afod_pkg::STABLE_W], st});
			if (p == 6) write_reg(REG_SPARE, $urandom);

			queue_random_samples(PHASE_SAMPLES);
			wait_drained();
		end

		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && expected_faces.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	// watchdog
	initial begin : watchdog
		#4000000;
		$display("tb: failure");
		$finish;
	end

endmodule

// ----- accel_face_orientation_detector.f -----
rtl/afod_pkg.sv
rtl/afod_front.sv
rtl/afod_queue.sv
rtl/afod_back.sv
rtl/accel_face_orientation_detector.sv
verif/accel_face_orientation_detector_tb.sv
